### hdl/tcte_pkg.sv
// ----------------------------------------------------------------------------
// tcte_pkg
// Types and constants shared by the connection table engine modules.
// ----------------------------------------------------------------------------
package tcte_pkg;

  // default table size and register reset value
  localparam int DEF_NUM_CONN = 16;
  localparam logic [15:0] WINDOW_RESET = 16'd4096;

  // configuration port
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_WINDOW = 3'd0;

  // action codes
  localparam logic [1:0] ACT_SEG  = 2'd0;
  localparam logic [1:0] ACT_BIND = 2'd1;
  localparam logic [1:0] ACT_FREE = 2'd2;

  // tcp control bits
  localparam logic [5:0] F_FIN = 6'h01;
  localparam logic [5:0] F_SYN = 6'h02;
  localparam logic [5:0] F_RST = 6'h04;
  localparam logic [5:0] F_PSH = 6'h08;
  localparam logic [5:0] F_ACK = 6'h10;

  // entry states
  localparam logic [2:0] ST_FREE      = 3'd0;
  localparam logic [2:0] ST_LISTEN    = 3'd1;
  localparam logic [2:0] ST_SYNRCVD   = 3'd2;
  localparam logic [2:0] ST_ESTAB     = 3'd3;
  localparam logic [2:0] ST_CLOSEWAIT = 3'd4;

  // event codes
  localparam logic [3:0] EV_DATA   = 4'd0;
  localparam logic [3:0] EV_ACK    = 4'd1;
  localparam logic [3:0] EV_FIN    = 4'd2;
  localparam logic [3:0] EV_SYNACK = 4'd3;
  localparam logic [3:0] EV_ESTAB  = 4'd4;
  localparam logic [3:0] EV_RESET  = 4'd5;
  localparam logic [3:0] EV_BOUND  = 4'd6;
  localparam logic [3:0] EV_INUSE  = 4'd7;
  localparam logic [3:0] EV_FULL   = 4'd8;
  localparam logic [3:0] EV_FREED  = 4'd9;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] local_ip;
    logic [15:0] local_port;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [5:0]  flags;
    logic [15:0] payload_len;
    logic [15:0] peer_window;
    logic [3:0]  free_index;
  } tcte_in_t;

  typedef struct packed {
    logic        reply_valid;
    logic [5:0]  reply_flags;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    logic [15:0] reply_window_res;
    logic [3:0]  event_res;
    logic [3:0]  entry_index;
    logic [3:0]  listener_index;
  } tcte_out_t;

  typedef enum logic [1:0] {
    CLS_SEG,
    CLS_BIND,
    CLS_FREE
  } tcte_cls_t;

  // queue entry between front and back
  typedef struct packed {
    tcte_cls_t cls;
    tcte_in_t  item;
  } tcte_job_t;

endpackage

### hdl/tcte_front.sv
// ----------------------------------------------------------------------------
// tcte_front
// Accepts input items, classifies the action and queues jobs for the back end.
// ----------------------------------------------------------------------------
module tcte_front import tcte_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tcte_in_t  in_data,
  output logic      q_valid,
  input  logic      q_ready,
  output tcte_job_t q_data
);

  tcte_job_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       known;
  tcte_cls_t  cls;
  logic       push;
  logic       pop;

  // classify the action, unused code is dropped
  always_comb begin
    known = 1'b1;
    cls   = CLS_SEG;
    unique case (in_data.action)
      ACT_SEG:  cls = CLS_SEG;
      ACT_BIND: cls = CLS_BIND;
      ACT_FREE: cls = CLS_FREE;
      default:  known = 1'b0;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot[rd_ptr];
  assign pop      = q_valid && q_ready;

  // two-entry job queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= '{cls: cls, item: in_data};
        wr_ptr       <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hdl/tcte_engine.sv
// ----------------------------------------------------------------------------
// tcte_engine
// Scans the connection table for a bind or segment job (a free skips the scan),
// decides and commits the update, and holds the result in an output register.
// ----------------------------------------------------------------------------
module tcte_engine import tcte_pkg::*; #(
  parameter int NUM_CONN = DEF_NUM_CONN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] reply_window,
  input  logic        q_valid,
  output logic        q_ready,
  input  tcte_job_t   q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tcte_out_t   out_data
);

  localparam int IDXW = $clog2(NUM_CONN);
  localparam logic [IDXW-1:0] LAST = IDXW'(NUM_CONN - 1);

  typedef struct packed {
    logic [31:0] lip;
    logic [15:0] lport;
    logic [31:0] rip;
    logic [15:0] rport;
    logic [31:0] una;
    logic [31:0] nxt;
    logic [31:0] rnx;
  } rec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t          st;
  tcte_job_t       cur;
  logic [IDXW-1:0] scan_addr;
  logic            issuing;
  logic            cmp_vld;
  logic [IDXW-1:0] cmp_idx;

  rec_t            mem [NUM_CONN];
  rec_t            rd_data;
  logic [2:0]      conn_state [NUM_CONN];

  // first-match results of the scan
  logic            est_hit, syn_hit, lx_hit, lw_hit, fr_hit;
  logic [IDXW-1:0] est_idx, syn_idx, lx_idx, lw_idx, fr_idx;
  logic [31:0]     est_una, est_nxt, est_rnx, syn_nxt;

  // compare stage
  logic [2:0]      cs;
  logic            tuple_eq, port_eq;
  logic            est_m, syn_m, lx_m, lw_m, fr_m;

  // decision
  logic            done_ok, commit;
  logic            lis_hit;
  logic [IDXW-1:0] lis_idx;
  logic [31:0]     past, left, una_new, seq_plen, seq_one;
  logic            slide_ok, handled;
  logic [3:0]      rst_ev;
  logic            mem_we, st_we;
  logic [IDXW-1:0] mem_wa, st_idx;
  logic [2:0]      st_w;
  rec_t            rec_w;
  tcte_out_t       res;

  assign q_ready = (st == S_IDLE);
  assign done_ok = !out_valid || out_ready;
  assign commit  = (st == S_DECIDE) && done_ok;

  // entry compare against the item
  always_comb begin
    cs       = conn_state[cmp_idx];
    port_eq  = (rd_data.lport == cur.item.local_port);
    tuple_eq = port_eq && (rd_data.lip == cur.item.local_ip) &&
               (rd_data.rip == cur.item.remote_ip) &&
               (rd_data.rport == cur.item.remote_port);
    est_m = (cs == ST_ESTAB) && tuple_eq;
    syn_m = (cs == ST_SYNRCVD) && tuple_eq;
    lx_m  = (cs == ST_LISTEN) && port_eq && (rd_data.lip == cur.item.local_ip);
    lw_m  = (cs == ST_LISTEN) && port_eq && (rd_data.lip == 32'd0);
    fr_m  = (cs == ST_FREE);
  end

  // decide the update and the result
  always_comb begin
    res      = '0;
    mem_we   = 1'b0;
    mem_wa   = fr_idx;
    rec_w    = '0;
    st_we    = 1'b0;
    st_idx   = fr_idx;
    st_w     = ST_FREE;
    handled  = 1'b0;
    rst_ev   = EV_RESET;
    lis_hit  = lx_hit || lw_hit;
    lis_idx  = lx_hit ? lx_idx : lw_idx;
    past     = cur.item.ack_num - est_una;
    left     = est_nxt - cur.item.ack_num;
    slide_ok = (past != 32'd0) && !past[31] && !left[31];
    una_new  = slide_ok ? cur.item.ack_num : est_una;
    seq_plen = cur.item.seq_num + {16'd0, cur.item.payload_len};
    seq_one  = cur.item.seq_num + 32'd1;
    rec_w.lip   = cur.item.local_ip;
    rec_w.lport = cur.item.local_port;
    rec_w.rip   = cur.item.remote_ip;
    rec_w.rport = cur.item.remote_port;

    unique case (cur.cls)
      CLS_FREE: begin
        res.event_res = EV_FREED;
        if (32'(cur.item.free_index) < NUM_CONN) begin
          st_we  = 1'b1;
          st_idx = IDXW'(cur.item.free_index);
          st_w   = ST_FREE;
          res.entry_index = cur.item.free_index;
        end
      end
      CLS_BIND: begin
        if (lis_hit) begin
          res.event_res = EV_INUSE;
        end else if (!fr_hit) begin
          res.event_res = EV_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = fr_idx;
          rec_w.rip   = 32'd0;
          rec_w.rport = 16'd0;
          st_we     = 1'b1;
          st_idx    = fr_idx;
          st_w      = ST_LISTEN;
          res.event_res   = EV_BOUND;
          res.entry_index = 4'(fr_idx);
        end
      end
      default: begin
        // established connection first
        if (est_hit) begin
          res.reply_valid      = 1'b1;
          res.reply_flags      = F_ACK;
          res.reply_seq        = est_nxt;
          res.reply_window_res = reply_window;
          res.entry_index      = 4'(est_idx);
          rec_w.nxt            = est_nxt;
          mem_wa               = est_idx;
          priority if (cur.item.flags == (F_PSH | F_ACK)) begin
            handled       = 1'b1;
            mem_we        = 1'b1;
            rec_w.una     = una_new;
            rec_w.rnx     = seq_plen;
            res.reply_ack = seq_plen;
            res.event_res = EV_DATA;
          end else if ((cur.item.flags & F_FIN) != 6'd0) begin
            handled       = 1'b1;
            mem_we        = 1'b1;
            rec_w.una     = est_una;
            rec_w.rnx     = seq_one;
            st_we         = 1'b1;
            st_idx        = est_idx;
            st_w          = ST_CLOSEWAIT;
            res.reply_ack = seq_one;
            res.event_res = EV_FIN;
          end else if (cur.item.flags == F_ACK) begin
            handled       = 1'b1;
            mem_we        = 1'b1;
            rec_w.una     = una_new;
            rec_w.rnx     = est_rnx;
            res.reply_ack = est_rnx;
            res.event_res = EV_ACK;
          end else begin
            handled = 1'b0;
          end
        end
        if (!handled) begin
          res = '0;
          // bare syn to a listener opens a child entry
          if (cur.item.flags == F_SYN && lis_hit) begin
            if (fr_hit) begin
              handled   = 1'b1;
              mem_we    = 1'b1;
              mem_wa    = fr_idx;
              rec_w.una = 32'd0;
              rec_w.nxt = 32'd1;
              rec_w.rnx = seq_one;
              st_we     = 1'b1;
              st_idx    = fr_idx;
              st_w      = ST_SYNRCVD;
              res.reply_valid      = 1'b1;
              res.reply_flags      = F_SYN | F_ACK;
              res.reply_ack        = seq_one;
              res.reply_window_res = reply_window;
              res.event_res        = EV_SYNACK;
              res.entry_index      = 4'(fr_idx);
              res.listener_index   = 4'(lis_idx);
            end else begin
              rst_ev = EV_FULL;
            end
          end
          // final ack of the handshake
          if (!handled && cur.item.flags == F_ACK && syn_hit &&
              cur.item.ack_num == syn_nxt) begin
            handled   = 1'b1;
            mem_we    = 1'b1;
            mem_wa    = syn_idx;
            rec_w.una = cur.item.ack_num;
            rec_w.nxt = syn_nxt;
            rec_w.rnx = seq_plen;
            st_we     = 1'b1;
            st_idx    = syn_idx;
            st_w      = ST_ESTAB;
            res.event_res      = EV_ESTAB;
            res.entry_index    = 4'(syn_idx);
            res.listener_index = lis_hit ? 4'(lis_idx) : 4'd0;
          end
          if (!handled) begin
            res.reply_valid      = 1'b1;
            res.reply_flags      = F_RST | F_ACK;
            res.reply_ack        = seq_one;
            res.reply_window_res = cur.item.peer_window;
            res.event_res        = rst_ev;
          end
        end
      end
    endcase
  end

  // record memory, one read port for the scan and one write port
  always_ff @(posedge clk) begin
    if (commit && mem_we) begin
      mem[mem_wa] <= rec_w;
    end
    rd_data <= mem[scan_addr];
  end

  // entry states, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CONN; i++) begin
        conn_state[i] <= ST_FREE;
      end
    end else if (commit && st_we) begin
      conn_state[st_idx] <= st_w;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      issuing   <= 1'b0;
      cmp_vld   <= 1'b0;
      scan_addr <= '0;
      est_hit   <= 1'b0;
      syn_hit   <= 1'b0;
      lx_hit    <= 1'b0;
      lw_hit    <= 1'b0;
      fr_hit    <= 1'b0;
    end else begin
      // result register
      if (commit) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (q_valid) begin
            cur     <= q_data;
            est_hit <= 1'b0;
            syn_hit <= 1'b0;
            lx_hit  <= 1'b0;
            lw_hit  <= 1'b0;
            fr_hit  <= 1'b0;
            if (q_data.cls == CLS_FREE) begin
              st <= S_DECIDE;
            end else begin
              st        <= S_SCAN;
              scan_addr <= '0;
              issuing   <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // issue reads one entry a cycle
          cmp_vld <= issuing;
          cmp_idx <= scan_addr;
          if (issuing) begin
            if (scan_addr == LAST) begin
              issuing <= 1'b0;
            end else begin
              scan_addr <= scan_addr + IDXW'(1);
            end
          end
          // keep the lowest matching index of each kind
          if (cmp_vld) begin
            if (!est_hit && est_m) begin
              est_hit <= 1'b1;
              est_idx <= cmp_idx;
              est_una <= rd_data.una;
              est_nxt <= rd_data.nxt;
              est_rnx <= rd_data.rnx;
            end
            if (!syn_hit && syn_m) begin
              syn_hit <= 1'b1;
              syn_idx <= cmp_idx;
              syn_nxt <= rd_data.nxt;
            end
            if (!lx_hit && lx_m) begin
              lx_hit <= 1'b1;
              lx_idx <= cmp_idx;
            end
            if (!lw_hit && lw_m) begin
              lw_hit <= 1'b1;
              lw_idx <= cmp_idx;
            end
            if (!fr_hit && fr_m) begin
              fr_hit <= 1'b1;
              fr_idx <= cmp_idx;
            end
            if (cmp_idx == LAST) begin
              st <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (done_ok) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // jobs are only taken while the sequencer is idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> (st == S_IDLE))
    else $error("job taken while busy");

  // a new result only appears after a decide cycle
  a_res_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == S_DECIDE))
    else $error("result without decision");

  // one entry cannot be both established and half open
  a_hits_distinct: assert property (@(posedge clk) disable iff (rst)
    (est_hit && syn_hit) |-> (est_idx != syn_idx))
    else $error("entry matched in two states");

  // the scan ends only on the last entry
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (st == S_SCAN && cmp_vld && cmp_idx != LAST) |=> (st == S_SCAN))
    else $error("scan left early");

endmodule

### hdl/tcp_connection_table_engine.sv
// ----------------------------------------------------------------------------
// tcp_connection_table_engine
// Passive-open tcp connection table: bind, free and received segment handling.
// ----------------------------------------------------------------------------
// Flow: a bind or segment is scanned over the whole table, one entry a cycle,
//   then decided; a free skips the scan. Decide holds until the output
//   register is free, and the engine takes a new job only when idle; a
//   two-entry queue takes further items while an item is being worked on.
// Reset: synchronous; all entries become free and reply_window returns to 4096.
module tcp_connection_table_engine import tcte_pkg::*; #(
  parameter int NUM_CONN = DEF_NUM_CONN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcte_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tcte_out_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0] reply_window;
  logic        q_valid;
  logic        q_ready;
  tcte_job_t   q_data;

  assign pready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_window <= WINDOW_RESET;
    end else if (psel && penable && pwrite && paddr == REG_WINDOW) begin
      reply_window <= pwdata[15:0];
    end
  end

  // register read back
  always_comb begin
    prdata = 32'd0;
    if (paddr == REG_WINDOW) begin
      prdata = {16'd0, reply_window};
    end
  end

  tcte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  tcte_engine #(
    .NUM_CONN (NUM_CONN)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .reply_window (reply_window),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
